### hdl/cipc_pkg.sv
// shared types, constants and microcode program of the cascade pi controller
`timescale 1ns / 1ps

package cipc_pkg;

    localparam int GAIN_FRAC_BITS = 8;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int GAIN_W         = 16;
    localparam int ACC_W          = 32;
    localparam int OUTER_PREV_W   = 18;
    localparam int ERR_W          = ACC_W + 2;
    localparam int DIFF_W         = ERR_W + 1;
    localparam int PROD_W         = DIFF_W + GAIN_W + 1;
    localparam int SUM_W          = PROD_W + 1;
    localparam int TRUNC_W        = SUM_W - GAIN_FRAC_BITS;
    localparam int BOUND_W        = 2 * GAIN_W;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int PC_W           = 4;

    localparam logic [GAIN_W-1:0] LIMIT_RESET = GAIN_W'(65);

    localparam logic [PC_W-1:0] PC_INNER_FIRST = PC_W'(6);
    localparam logic [PC_W-1:0] PC_OUT         = PC_W'(12);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OUTER_GAIN_P   = 3'd0,
        REG_OUTER_GAIN_I   = 3'd1,
        REG_INNER_GAIN_P   = 3'd2,
        REG_INNER_GAIN_I   = 3'd3,
        REG_INTEGRAL_LIMIT = 3'd4,
        REG_CASCADE_ENABLE = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        OP_ERR,
        OP_MULI,
        OP_MULP,
        OP_SUM,
        OP_TRUNC,
        OP_ACC,
        OP_OUT
    } op_t;

    typedef enum logic {
        JMP_NONE,
        JMP_NO_CASCADE
    } jmp_t;

    typedef struct packed {
        op_t             op;
        logic            inner;
        jmp_t            jmp;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic [GAIN_W-1:0] outer_gain_p;
        logic [GAIN_W-1:0] outer_gain_i;
        logic [GAIN_W-1:0] inner_gain_p;
        logic [GAIN_W-1:0] inner_gain_i;
        logic [GAIN_W-1:0] integral_limit;
        logic              cascade_enable;
    } cfg_t;

    typedef struct packed {
        logic step;
        op_t  op;
        logic inner;
        logic load_in;
    } ctrl_t;

    typedef struct packed {
        logic            busy;
        logic [PC_W-1:0] pc;
        logic            fin;
    } seq_stat_t;

    // microcode program: outer stage, optional inner stage, then result write
    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: OP_OUT, inner: 1'b0, jmp: JMP_NONE, target: '0};
        case (pc)
            PC_W'(0):  w = '{op: OP_ERR,   inner: 1'b0, jmp: JMP_NONE, target: '0};
            PC_W'(1):  w = '{op: OP_MULI,  inner: 1'b0, jmp: JMP_NONE, target: '0};
            PC_W'(2):  w = '{op: OP_MULP,  inner: 1'b0, jmp: JMP_NONE, target: '0};
            PC_W'(3):  w = '{op: OP_SUM,   inner: 1'b0, jmp: JMP_NONE, target: '0};
            PC_W'(4):  w = '{op: OP_TRUNC, inner: 1'b0, jmp: JMP_NONE, target: '0};
            PC_W'(5):  w = '{op: OP_ACC,   inner: 1'b0, jmp: JMP_NO_CASCADE, target: PC_OUT};
            PC_W'(6):  w = '{op: OP_ERR,   inner: 1'b1, jmp: JMP_NONE, target: '0};
            PC_W'(7):  w = '{op: OP_MULI,  inner: 1'b1, jmp: JMP_NONE, target: '0};
            PC_W'(8):  w = '{op: OP_MULP,  inner: 1'b1, jmp: JMP_NONE, target: '0};
            PC_W'(9):  w = '{op: OP_SUM,   inner: 1'b1, jmp: JMP_NONE, target: '0};
            PC_W'(10): w = '{op: OP_TRUNC, inner: 1'b1, jmp: JMP_NONE, target: '0};
            PC_W'(11): w = '{op: OP_ACC,   inner: 1'b1, jmp: JMP_NONE, target: '0};
            default:   w = '{op: OP_OUT,   inner: 1'b0, jmp: JMP_NONE, target: '0};
        endcase
        return w;
    endfunction

endpackage

### hdl/cipc_sequencer.sv
// step counter and microcode decode for the pi datapath
`timescale 1ns / 1ps

module cipc_sequencer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                cascade,
    input  logic                out_free,
    output cipc_pkg::ctrl_t     ctrl,
    output cipc_pkg::seq_stat_t stat
);

    logic                        busy_reg;
    logic                        busy_next;
    logic [cipc_pkg::PC_W-1:0]   pc_reg;
    logic [cipc_pkg::PC_W-1:0]   pc_next;
    cipc_pkg::uword_t            word;
    logic                        fin;

    assign word = cipc_pkg::ucode(pc_reg);
    assign fin  = busy_reg && (word.op == cipc_pkg::OP_OUT) && out_free;

    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            pc_next   = '0;
        end
        else if (fin)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg && (word.op != cipc_pkg::OP_OUT))
        begin
            if ((word.jmp == cipc_pkg::JMP_NO_CASCADE) && !cascade)
            begin
                pc_next = word.target;
            end
            else
            begin
                pc_next = pc_reg + cipc_pkg::PC_W'(1);
            end
        end
    end

    always_comb
    begin
        ctrl.step    = busy_reg;
        ctrl.op      = word.op;
        ctrl.inner   = word.inner;
        ctrl.load_in = start;
        stat.busy    = busy_reg;
        stat.pc      = pc_reg;
        stat.fin     = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pc_reg   <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            pc_reg   <= pc_next;
        end
    end

endmodule

### hdl/cipc_datapath.sv
// shared multiplier datapath and loop state of both pi stages
`timescale 1ns / 1ps

module cipc_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cipc_pkg::ctrl_t                        ctrl,
    input  cipc_pkg::cfg_t                         cfg,
    input  logic signed [cipc_pkg::SAMPLE_WIDTH-1:0] outer_feedback,
    input  logic signed [cipc_pkg::SAMPLE_WIDTH-1:0] outer_target,
    input  logic signed [cipc_pkg::SAMPLE_WIDTH-1:0] inner_target,
    output logic signed [cipc_pkg::ACC_W-1:0]      drive,
    output logic signed [cipc_pkg::ACC_W-1:0]      outer_drive
);

    localparam int SW  = cipc_pkg::SAMPLE_WIDTH;
    localparam int AW  = cipc_pkg::ACC_W;
    localparam int EW  = cipc_pkg::ERR_W;
    localparam int DW  = cipc_pkg::DIFF_W;
    localparam int PW  = cipc_pkg::PROD_W;
    localparam int SMW = cipc_pkg::SUM_W;
    localparam int TW  = cipc_pkg::TRUNC_W;
    localparam int BW  = cipc_pkg::BOUND_W;
    localparam int GW  = cipc_pkg::GAIN_W;
    localparam int FB  = cipc_pkg::GAIN_FRAC_BITS;

    localparam logic signed [SMW-1:0] TRUNC_BIAS = SMW'((64'd1 << FB) - 64'd1);

    logic signed [SW-1:0]  fb_reg;
    logic signed [SW-1:0]  tg_reg;
    logic signed [SW-1:0]  it_reg;
    logic signed [EW-1:0]  err_reg;
    logic signed [DW-1:0]  diff_reg;
    logic signed [PW-1:0]  integ_reg;
    logic signed [PW-1:0]  prop_reg;
    logic        [BW-1:0]  bound_reg;
    logic signed [SMW-1:0] sum_reg;
    logic signed [TW-1:0]  trunc_reg;
    logic signed [cipc_pkg::OUTER_PREV_W-1:0] outer_prev_reg;
    logic signed [EW-1:0]  inner_prev_reg;
    logic signed [AW-1:0]  outer_acc_reg;
    logic signed [AW-1:0]  inner_acc_reg;

    logic signed [EW-1:0]  minuend;
    logic signed [EW-1:0]  subtrahend;
    logic signed [EW-1:0]  err_new;
    logic signed [EW-1:0]  prev_sel;
    logic        [GW-1:0]  gain_p;
    logic        [GW-1:0]  gain_i;
    logic signed [GW:0]    mul_a;
    logic signed [DW-1:0]  mul_b;
    logic signed [PW-1:0]  product;
    logic        [BW-1:0]  bound_new;
    logic signed [PW-1:0]  bound_pos;
    logic signed [PW-1:0]  bound_neg;
    logic signed [PW-1:0]  integ_clamped;
    logic signed [SMW-1:0] sum_new;
    logic signed [SMW-1:0] sum_biased;
    logic signed [TW-1:0]  trunc_new;
    logic signed [AW-1:0]  acc_sel;
    logic signed [TW:0]    acc_sum;
    logic        [TW-AW+1:0] acc_top;
    logic signed [AW-1:0]  acc_sat;

    always_comb
    begin
        gain_p     = ctrl.inner ? cfg.inner_gain_p : cfg.outer_gain_p;
        gain_i     = ctrl.inner ? cfg.inner_gain_i : cfg.outer_gain_i;
        minuend    = ctrl.inner ? EW'(it_reg) : EW'(tg_reg);
        subtrahend = ctrl.inner ? EW'(outer_acc_reg) : EW'(fb_reg);
        err_new    = minuend - subtrahend;
        prev_sel   = ctrl.inner ? inner_prev_reg : EW'(outer_prev_reg);
        acc_sel    = ctrl.inner ? inner_acc_reg : outer_acc_reg;

        // one shared signed multiplier, gain zero-extended
        mul_a   = signed'({1'b0, ((ctrl.op == cipc_pkg::OP_MULI) ? gain_i : gain_p)});
        mul_b   = (ctrl.op == cipc_pkg::OP_MULI) ? DW'(err_reg) : diff_reg;
        product = PW'(mul_a) * PW'(mul_b);

        bound_new = gain_i * cfg.integral_limit;
        bound_pos = signed'({{(PW - BW){1'b0}}, bound_reg});
        bound_neg = -bound_pos;
        if (integ_reg > bound_pos)
        begin
            integ_clamped = bound_pos;
        end
        else if (integ_reg < bound_neg)
        begin
            integ_clamped = bound_neg;
        end
        else
        begin
            integ_clamped = integ_reg;
        end

        sum_new = SMW'(prop_reg) + SMW'(integ_reg);

        // truncate toward zero: bias negative values before the shift
        sum_biased = sum_reg + (sum_reg[SMW-1] ? TRUNC_BIAS : '0);
        trunc_new  = TW'(sum_biased >>> FB);

        acc_sum = (TW + 1)'(acc_sel) + (TW + 1)'(trunc_reg);
        acc_top = acc_sum[TW:AW-1];
        if ((&acc_top) || !(|acc_top))
        begin
            acc_sat = acc_sum[AW-1:0];
        end
        else if (acc_sum[TW])
        begin
            acc_sat = signed'({1'b1, {(AW - 1){1'b0}}});
        end
        else
        begin
            acc_sat = signed'({1'b0, {(AW - 1){1'b1}}});
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            fb_reg <= outer_feedback;
            tg_reg <= outer_target;
            it_reg <= inner_target;
        end
        if (ctrl.step)
        begin
            case (ctrl.op)
                cipc_pkg::OP_ERR:
                begin
                    err_reg <= err_new;
                end
                cipc_pkg::OP_MULI:
                begin
                    integ_reg <= product;
                    bound_reg <= bound_new;
                    diff_reg  <= DW'(err_reg) - DW'(prev_sel);
                end
                cipc_pkg::OP_MULP:
                begin
                    prop_reg  <= product;
                    integ_reg <= integ_clamped;
                end
                cipc_pkg::OP_SUM:
                begin
                    sum_reg <= sum_new;
                end
                cipc_pkg::OP_TRUNC:
                begin
                    trunc_reg <= trunc_new;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outer_prev_reg <= '0;
            inner_prev_reg <= '0;
            outer_acc_reg  <= '0;
            inner_acc_reg  <= '0;
        end
        else if (ctrl.step && (ctrl.op == cipc_pkg::OP_ACC))
        begin
            if (ctrl.inner)
            begin
                inner_acc_reg  <= acc_sat;
                inner_prev_reg <= err_reg;
            end
            else
            begin
                outer_acc_reg  <= acc_sat;
                outer_prev_reg <= cipc_pkg::OUTER_PREV_W'(err_reg);
            end
        end
    end

    assign drive       = cfg.cascade_enable ? inner_acc_reg : outer_acc_reg;
    assign outer_drive = outer_acc_reg;

endmodule

### hdl/cascade_incremental_pi_controller_core.sv
// top level: config registers, input/output beats, sequencer and datapath
// the microcode program runs the outer stage alone, or both stages in cascade mode,
// on one shared multiplier; a new input beat is taken only once the previous sample
// has finished: the next input beat is taken in the cycle the previous result enters
// the output register, which waits while a pending result beat is stalled downstream
// reset: rst_n asynchronous active low; clears accumulators and previous errors,
// gains to zero, integral limit to 65, cascade enabled
`timescale 1ns / 1ps

module cascade_incremental_pi_controller_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [cipc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cipc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // outer_feedback [15:0], outer_target [31:16], inner_target [47:32]
    input  logic [3*cipc_pkg::SAMPLE_WIDTH-1:0] s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // drive [31:0], outer_drive [63:32]
    output logic [2*cipc_pkg::ACC_W-1:0]        m_axis_tdata
);

    localparam int SW = cipc_pkg::SAMPLE_WIDTH;
    localparam int AW = cipc_pkg::ACC_W;

    cipc_pkg::cfg_t      cfg_reg;
    cipc_pkg::ctrl_t     ctrl;
    cipc_pkg::seq_stat_t stat;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [2*AW-1:0]      out_data_reg;
    logic                 out_free;
    logic                 accept;
    logic signed [AW-1:0] drive;
    logic signed [AW-1:0] outer_drive;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.outer_gain_p   <= '0;
            cfg_reg.outer_gain_i   <= '0;
            cfg_reg.inner_gain_p   <= '0;
            cfg_reg.inner_gain_i   <= '0;
            cfg_reg.integral_limit <= cipc_pkg::LIMIT_RESET;
            cfg_reg.cascade_enable <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                cipc_pkg::REG_OUTER_GAIN_P:   cfg_reg.outer_gain_p   <= cfg_data;
                cipc_pkg::REG_OUTER_GAIN_I:   cfg_reg.outer_gain_i   <= cfg_data;
                cipc_pkg::REG_INNER_GAIN_P:   cfg_reg.inner_gain_p   <= cfg_data;
                cipc_pkg::REG_INNER_GAIN_I:   cfg_reg.inner_gain_i   <= cfg_data;
                cipc_pkg::REG_INTEGRAL_LIMIT: cfg_reg.integral_limit <= cfg_data;
                cipc_pkg::REG_CASCADE_ENABLE: cfg_reg.cascade_enable <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !stat.busy || stat.fin;
    assign accept        = s_axis_tvalid && s_axis_tready;

    cipc_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .cascade  (cfg_reg.cascade_enable),
        .out_free (out_free),
        .ctrl     (ctrl),
        .stat     (stat)
    );

    cipc_datapath u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cfg            (cfg_reg),
        .outer_feedback (signed'(s_axis_tdata[SW-1:0])),
        .outer_target   (signed'(s_axis_tdata[2*SW-1:SW])),
        .inner_target   (signed'(s_axis_tdata[3*SW-1:2*SW])),
        .drive          (drive),
        .outer_drive    (outer_drive)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (stat.fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.fin)
        begin
            out_data_reg <= {outer_drive, drive};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // an accepted beat starts the program at its first step
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (stat.busy && (stat.pc == '0)))
        else $error("program did not start on input beat");

    // a result never overwrites a beat still waiting downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.fin |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result written over a pending beat");

    // the written result carries the outer accumulator of that sample
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.fin |=> (m_axis_tvalid && (m_axis_tdata[2*AW-1:AW] == $past(outer_drive))))
        else $error("outer drive field mismatch");

endmodule

### tb/sv/pi_drive_checker.sv
// checker: watches config writes and both streams, predicts drive words and compares them
`timescale 1ns / 1ps

module pi_drive_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [cipc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cipc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // outer_feedback [15:0], outer_target [31:16], inner_target [47:32]
    input  logic [3*cipc_pkg::SAMPLE_WIDTH-1:0] s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // drive [31:0], outer_drive [63:32]
    input  logic [2*cipc_pkg::ACC_W-1:0]        m_axis_tdata,
    output int                                  fails,
    output int                                  pending
);

    import cipc_pkg::*;

    typedef struct packed {
        logic [ACC_W-1:0] outer_drive;
        logic [ACC_W-1:0] drive;
    } drive_pair_t;

    localparam longint ACC_HI = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_LO = -(longint'(1) <<< (ACC_W - 1));

    drive_pair_t drive_q[$];

    logic [GAIN_W-1:0] gp_outer;
    logic [GAIN_W-1:0] gi_outer;
    logic [GAIN_W-1:0] gp_inner;
    logic [GAIN_W-1:0] gi_inner;
    logic [GAIN_W-1:0] limit_reg;
    logic              cascade_on;

    longint prev_err_outer;
    longint acc_outer;
    longint prev_err_inner;
    longint acc_inner;

    // one incremental pi step: returns the new accumulator
    function automatic longint pi_stage_next(input longint err, input longint prev_err,
                                             input longint acc, input logic [GAIN_W-1:0] gp,
                                             input logic [GAIN_W-1:0] gi,
                                             input logic [GAIN_W-1:0] lim);
        longint bound;
        longint integ;
        longint total;
        longint next_acc;
        bound = longint'(gi) * longint'(lim);
        integ = longint'(gi) * err;
        if (integ > bound)
            integ = bound;
        else if (integ < -bound)
            integ = -bound;
        total = longint'(gp) * (err - prev_err) + integ;
        // signed division drops the fraction toward zero
        next_acc = acc + total / (longint'(1) <<< GAIN_FRAC_BITS);
        if (next_acc > ACC_HI)
            next_acc = ACC_HI;
        else if (next_acc < ACC_LO)
            next_acc = ACC_LO;
        return next_acc;
    endfunction

    task automatic report_miss(input string msg);
        fails++;
        if (fails <= 10)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_pair_t want;
        drive_pair_t got;
        logic signed [SAMPLE_WIDTH-1:0] fb;
        logic signed [SAMPLE_WIDTH-1:0] tg;
        logic signed [SAMPLE_WIDTH-1:0] it;
        longint err;
        if (!rst_n)
        begin
            gp_outer       = '0;
            gi_outer       = '0;
            gp_inner       = '0;
            gi_inner       = '0;
            limit_reg      = LIMIT_RESET;
            cascade_on     = 1'b1;
            prev_err_outer = 0;
            acc_outer      = 0;
            prev_err_inner = 0;
            acc_inner      = 0;
            drive_q.delete();
            fails          = 0;
            pending        = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_OUTER_GAIN_P:   gp_outer = cfg_data[GAIN_W-1:0];
                    REG_OUTER_GAIN_I:   gi_outer = cfg_data[GAIN_W-1:0];
                    REG_INNER_GAIN_P:   gp_inner = cfg_data[GAIN_W-1:0];
                    REG_INNER_GAIN_I:   gi_inner = cfg_data[GAIN_W-1:0];
                    REG_INTEGRAL_LIMIT: limit_reg = cfg_data[GAIN_W-1:0];
                    REG_CASCADE_ENABLE: cascade_on = cfg_data[0];
                    default: ;
                endcase
            end

            // check the result beat before queuing this edge's input beat
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (drive_q.size() == 0)
                    report_miss($sformatf("result beat with nothing pending: drive %h outer %h",
                                          got.drive, got.outer_drive));
                else
                begin
                    want = drive_q.pop_front();
                    if (got.drive !== want.drive)
                        report_miss($sformatf("drive expected %h got %h",
                                              want.drive, got.drive));
                    if (got.outer_drive !== want.outer_drive)
                        report_miss($sformatf("outer_drive expected %h got %h",
                                              want.outer_drive, got.outer_drive));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                {it, tg, fb} = s_axis_tdata;
                err = longint'(tg) - longint'(fb);
                acc_outer = pi_stage_next(err, prev_err_outer, acc_outer,
                                          gp_outer, gi_outer, limit_reg);
                prev_err_outer = err;
                want.outer_drive = acc_outer[ACC_W-1:0];
                want.drive = acc_outer[ACC_W-1:0];
                if (cascade_on)
                begin
                    // inner error uses the freshly updated outer accumulator
                    err = longint'(it) - acc_outer;
                    acc_inner = pi_stage_next(err, prev_err_inner, acc_inner,
                                              gp_inner, gi_inner, limit_reg);
                    prev_err_inner = err;
                    want.drive = acc_inner[ACC_W-1:0];
                end
                drive_q.push_back(want);
            end
            pending = drive_q.size();
        end
    end

endmodule

### tb/sv/tb.sv
// testbench top: clock, reset, config writes, sample stimulus, result backpressure, verdict
`timescale 1ns / 1ps

module tb;

    import cipc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_LO = CFG_INDEX_W'(6);
    localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_HI = CFG_INDEX_W'(7);

    localparam int STYLE_WIDE = 0;
    localparam int STYLE_NEAR = 1;
    localparam int STYLE_UP   = 2;
    localparam int STYLE_DOWN = 3;

    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 250;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [3*SAMPLE_WIDTH-1:0]     s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [2*ACC_W-1:0]            m_axis_tdata;

    int fails;
    int pending;
    bit quiet = 1'b0;
    int out_hold = 0;

    always #1 clk = ~clk;

    cascade_incremental_pi_controller_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pi_drive_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fails         (fails),
        .pending       (pending)
    );

    function automatic int draw_wait();
        if (quiet)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'(1 << GAIN_FRAC_BITS);
            3:       return CFG_DATA_W'($urandom_range(0, 1023));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return LIMIT_RESET;
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    // result side: stall after some beats and at random idle points
    always @(posedge clk or negedge rst_n)
    begin
        int hold;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            out_hold <= 0;
        end
        else if (m_axis_tready)
        begin
            if (m_axis_tvalid || $urandom_range(0, 5) == 0)
            begin
                hold = draw_wait();
                out_hold <= hold;
                m_axis_tready <= (hold == 0);
            end
        end
        else if (out_hold > 1)
            out_hold <= out_hold - 1;
        else
            m_axis_tready <= 1'b1;
    end

    // called at a rising edge; returns at a rising edge
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // returns at the edge where the beat was taken, tvalid still high
    task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] fb,
                               input logic [SAMPLE_WIDTH-1:0] tg,
                               input logic [SAMPLE_WIDTH-1:0] it);
        int gap;
        gap = draw_wait();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            // hold off until the block could take a beat, then a bit longer
            do
                @(posedge clk);
            while (!s_axis_tready);
            repeat (gap - 1) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it, tg, fb};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        // let a beat taken at this edge reach the pending count first
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    task automatic configure_phase(input int style);
        logic [CFG_DATA_W-1:0] casc_word;
        write_reg(REG_OUTER_GAIN_P, pick_gain());
        write_reg(REG_INNER_GAIN_P, pick_gain());
        write_reg(REG_INNER_GAIN_I, pick_gain());
        if (style == STYLE_UP || style == STYLE_DOWN)
        begin
            // strong integral action so the outer accumulator runs into its rails
            write_reg(REG_OUTER_GAIN_I, '1);
            write_reg(REG_INTEGRAL_LIMIT, '1);
        end
        else
        begin
            write_reg(REG_OUTER_GAIN_I, pick_gain());
            write_reg(REG_INTEGRAL_LIMIT, pick_limit());
        end
        casc_word = CFG_DATA_W'($urandom);
        casc_word[0] = ($urandom_range(0, 2) != 0);
        write_reg(REG_CASCADE_ENABLE, casc_word);
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO, CFG_DATA_W'($urandom));
    endtask

    task automatic run_phase(input int style, input int n);
        logic [SAMPLE_WIDTH-1:0] fb;
        logic [SAMPLE_WIDTH-1:0] tg;
        logic [SAMPLE_WIDTH-1:0] it;
        for (int k = 0; k < n; k++)
        begin
            fb = SAMPLE_WIDTH'($urandom);
            tg = SAMPLE_WIDTH'($urandom);
            it = SAMPLE_WIDTH'($urandom);
            case (style)
                STYLE_NEAR: tg = fb + SAMPLE_WIDTH'($urandom_range(0, 64)) - SAMPLE_WIDTH'(32);
                STYLE_UP:
                begin
                    fb[SAMPLE_WIDTH-1] = 1'b1;
                    tg[SAMPLE_WIDTH-1] = 1'b0;
                end
                STYLE_DOWN:
                begin
                    fb[SAMPLE_WIDTH-1] = 1'b0;
                    tg[SAMPLE_WIDTH-1] = 1'b1;
                end
                default: ;
            endcase
            if ($urandom_range(0, 99) == 0)
                wait_drained();
            send_sample(fb, tg, it);
        end
    endtask

    initial
    begin
        int style;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: zero gains, only the previous errors move
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h7FFF, 16'h8000);
        wait_drained();

        // moderate gains, default integral limit clamps the big errors
        write_reg(REG_OUTER_GAIN_P, 16'h0100);
        write_reg(REG_OUTER_GAIN_I, 16'h0080);
        write_reg(REG_INNER_GAIN_P, 16'h0200);
        write_reg(REG_INNER_GAIN_I, 16'h0040);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
        send_sample(16'h8000, 16'h7FFF, 16'h8000);
        send_sample(16'h0000, 16'h0064, 16'h0000);
        send_sample(16'h0064, 16'h0000, 16'h0032);
        send_sample(16'h0005, 16'h0005, 16'h0005);
        wait_drained();

        // full-scale gains: inner accumulator hits its rails
        write_reg(REG_OUTER_GAIN_P, 16'hFFFF);
        write_reg(REG_OUTER_GAIN_I, 16'hFFFF);
        write_reg(REG_INNER_GAIN_P, 16'hFFFF);
        write_reg(REG_INNER_GAIN_I, 16'hFFFF);
        write_reg(REG_INTEGRAL_LIMIT, 16'hFFFF);
        send_sample(16'h8000, 16'h7FFF, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000, 16'h8000);
        send_sample(16'h8000, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h7FFF, 16'h8000);
        wait_drained();

        // zero limit removes the integral term
        write_reg(REG_INTEGRAL_LIMIT, 16'h0000);
        send_sample(16'h1234, 16'hFEDC, 16'h0001);
        send_sample(16'hFFFF, 16'h0001, 16'hFFFF);
        wait_drained();

        // outer stage alone; only bit 0 of the cascade word counts
        write_reg(REG_CASCADE_ENABLE, 16'hFFFE);
        write_reg(REG_INTEGRAL_LIMIT, LIMIT_RESET);
        send_sample(16'h8000, 16'h7FFF, 16'h7FFF);
        send_sample(16'h0100, 16'h0080, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h0000);
        wait_drained();

        // writes to unused indexes leave the registers alone
        write_reg(IDX_SPARE_LO, 16'hFFFF);
        write_reg(IDX_SPARE_HI, 16'h1234);
        send_sample(16'h0010, 16'h0020, 16'h0030);
        send_sample(16'hFFF0, 16'hFFE0, 16'hFFD0);
        wait_drained();

        write_reg(REG_CASCADE_ENABLE, 16'h0001);
        send_sample(16'h0000, 16'h7FFF, 16'h7FFF);
        send_sample(16'h7FFF, 16'h0000, 16'h8000);
        wait_drained();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0, 5:    style = STYLE_WIDE;
                1, 7:    style = STYLE_NEAR;
                2, 6:    style = STYLE_UP;
                default: style = STYLE_DOWN;
            endcase
            quiet = (ph == 1) || ($urandom_range(0, 3) == 0);
            configure_phase(style);
            run_phase(style, PHASE_ITEMS);
            wait_drained();
        end

        quiet = 1'b0;
        repeat (20) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
